FILE: sv/pwc_pkg.sv
// Shared constants, codes and item types of the pre-trigger waveform capture block.
package pwc_pkg;

  // Capture geometry
  localparam int unsigned AnalogChannels    = 4;
  localparam int unsigned BinaryChannels    = 16;
  localparam int unsigned SamplesPerPeriod  = 32;
  localparam int unsigned CapturePeriods    = 16;
  localparam int unsigned DefaultPrePeriods = 2;
  localparam int unsigned CaptureDepth      = 512;

  // Field widths
  localparam int unsigned ChanW    = 16;
  localparam int unsigned AnalogW  = 64;
  localparam int unsigned BinaryW  = 16;
  localparam int unsigned SourceW  = 16;
  localparam int unsigned ReqW     = 3;
  localparam int unsigned PreW     = 8;
  localparam int unsigned PosW     = $clog2(CaptureDepth);
  localparam int unsigned CountW   = $clog2(CaptureDepth + 1);

  // Configuration port
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned RegIdxW  = 1;

  typedef enum logic [RegIdxW-1:0] {
    RegPreTriggerPeriods = 1'b0
  } reg_idx_e;

  typedef enum logic [ReqW-1:0] {
    ReqTick    = 3'd0,
    ReqTrigger = 3'd1,
    ReqStart   = 3'd2,
    ReqStop    = 3'd3,
    ReqRead    = 3'd4
  } req_e;

  typedef enum logic [1:0] {
    CapStopped = 2'd0,
    CapPre     = 2'd1,
    CapPost    = 2'd2
  } cap_state_e;

  typedef struct packed {
    logic [ReqW-1:0]    req_type;
    logic [AnalogW-1:0] analog_samples;
    logic [BinaryW-1:0] binary_inputs;
    logic [SourceW-1:0] trigger_source;
    logic [PosW-1:0]    read_position;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         capture_state;
    logic [PosW-1:0]    write_position;
    logic [CountW-1:0]  stored_count;
    logic               capture_done;
    logic [PosW-1:0]    end_position;
    logic [SourceW-1:0] held_trigger_source;
    logic [AnalogW-1:0] read_analog;
    logic [BinaryW-1:0] read_binary;
  } out_item_t;

  // Clamp the requested pre-trigger periods and scale to samples
  function automatic logic [CountW-1:0] pre_len_f(logic [PreW-1:0] periods);
    logic [PreW-1:0] p;
    int unsigned     len;
    p = periods;
    if (p <= PreW'(1)) begin
      p = PreW'(DefaultPrePeriods);
    end else if (p > PreW'(CapturePeriods / 2)) begin
      p = PreW'(CapturePeriods / 2);
    end
    len = 32'(p) * SamplesPerPeriod;
    if (len > CaptureDepth) begin
      len = CaptureDepth;
    end
    return CountW'(len);
  endfunction

endpackage

FILE: sv/pwc_chan_if.sv
// Valid/ready channel carrying one item per handshake.
interface pwc_chan_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: sv/pwc_core.sv
// Capture state, sample ring memories and the registered result stage.
module pwc_core #(
  parameter int unsigned ANALOG_CHANNELS = pwc_pkg::AnalogChannels,
  parameter int unsigned BINARY_CHANNELS = pwc_pkg::BinaryChannels
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [pwc_pkg::PreW-1:0] pre_periods_i,
  pwc_chan_if.sink                 in_i,
  pwc_chan_if.source               res_o
);
  import pwc_pkg::*;

  localparam int unsigned AnaW = ANALOG_CHANNELS * ChanW;

  typedef struct packed {
    logic [1:0]         capture_state;
    logic [PosW-1:0]    write_position;
    logic [CountW-1:0]  stored_count;
    logic               capture_done;
    logic [PosW-1:0]    end_position;
    logic [SourceW-1:0] held_trigger_source;
  } status_t;

  logic [PosW-1:0]    pos_q, pos_d;
  logic [CountW-1:0]  count_q, count_d;
  logic [CountW-1:0]  pre_len_q, pre_len_d;
  logic               running_q, running_d;
  logic               trig_q, trig_d;
  logic [PosW-1:0]    end_pos_q, end_pos_d;
  logic [SourceW-1:0] src_q, src_d;

  logic               s1_valid_q, s1_valid_d;
  logic               s1_read_q;
  status_t            s1_status_q, status_d;
  logic [AnaW-1:0]    rd_ana_q;
  logic [BINARY_CHANNELS-1:0] rd_bin_q;

  logic               accept;
  logic               done;
  logic               wr_en;
  logic               rd_en;
  logic [PosW-1:0]    next_pos;
  in_item_t           item;

  logic [AnaW-1:0]            ana_mem [CaptureDepth];
  logic [BINARY_CHANNELS-1:0] bin_mem [CaptureDepth];

  assign item        = in_i.payload;
  assign in_i.ready  = !s1_valid_q || res_o.ready;
  assign accept      = in_i.valid && in_i.ready;

  // Ring position of the sample on this tick
  always_comb begin
    if (count_q == '0) begin
      next_pos = '0;
    end else if (pos_q == PosW'(CaptureDepth - 1)) begin
      next_pos = '0;
    end else begin
      next_pos = pos_q + 1'b1;
    end
  end

  // Decode the request and work out the next capture state
  always_comb begin
    pos_d     = pos_q;
    count_d   = count_q;
    pre_len_d = pre_len_q;
    running_d = running_q;
    trig_d    = trig_q;
    end_pos_d = end_pos_q;
    src_d     = src_q;
    done      = 1'b0;
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    if (accept) begin
      case (item.req_type)
        ReqTick: begin
          if (running_q) begin
            wr_en = 1'b1;
            if (!trig_q) begin
              if (pre_len_q > count_q) begin
                count_d = count_q + 1'b1;
              end
              pos_d = next_pos;
            end else if (count_q < CountW'(CaptureDepth)) begin
              count_d = count_q + 1'b1;
              pos_d   = next_pos;
            end else begin
              end_pos_d = next_pos;
              running_d = 1'b0;
              trig_d    = 1'b0;
              pos_d     = '0;
              count_d   = '0;
              done      = 1'b1;
            end
          end
        end
        ReqTrigger: begin
          if (running_q && !trig_q) begin
            trig_d = 1'b1;
            src_d  = item.trigger_source;
          end
        end
        ReqStart: begin
          pre_len_d = pre_len_f(pre_periods_i);
          pos_d     = '0;
          count_d   = '0;
          trig_d    = 1'b0;
          end_pos_d = '0;
          src_d     = '0;
          running_d = 1'b1;
        end
        ReqStop: begin
          running_d = 1'b0;
        end
        ReqRead: begin
          rd_en = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Status after this item
  always_comb begin
    if (!running_d) begin
      status_d.capture_state = CapStopped;
    end else if (trig_d) begin
      status_d.capture_state = CapPost;
    end else begin
      status_d.capture_state = CapPre;
    end
    status_d.write_position      = pos_d;
    status_d.stored_count        = count_d;
    status_d.capture_done        = done;
    status_d.end_position        = end_pos_d;
    status_d.held_trigger_source = src_d;
  end

  // Hold the result stage until the output buffer takes it
  always_comb begin
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (res_o.ready) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      count_q    <= '0;
      pre_len_q  <= '0;
      running_q  <= 1'b0;
      trig_q     <= 1'b0;
      end_pos_q  <= '0;
      src_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      pos_q      <= pos_d;
      count_q    <= count_d;
      pre_len_q  <= pre_len_d;
      running_q  <= running_d;
      trig_q     <= trig_d;
      end_pos_q  <= end_pos_d;
      src_q      <= src_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  // Result payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_status_q <= status_d;
      s1_read_q   <= rd_en;
    end
  end

  // Sample ring: one write on a tick, one registered read on a read request
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ana_mem[next_pos] <= item.analog_samples[AnaW-1:0];
      bin_mem[next_pos] <= item.binary_inputs[BINARY_CHANNELS-1:0];
    end
    if (rd_en) begin
      rd_ana_q <= ana_mem[item.read_position];
      rd_bin_q <= bin_mem[item.read_position];
    end
  end

  // Drive the result item, read data zero unless this was a read
  assign res_o.valid                       = s1_valid_q;
  assign res_o.payload.capture_state       = s1_status_q.capture_state;
  assign res_o.payload.write_position      = s1_status_q.write_position;
  assign res_o.payload.stored_count        = s1_status_q.stored_count;
  assign res_o.payload.capture_done        = s1_status_q.capture_done;
  assign res_o.payload.end_position        = s1_status_q.end_position;
  assign res_o.payload.held_trigger_source = s1_status_q.held_trigger_source;
  assign res_o.payload.read_analog  = s1_read_q ? AnalogW'(rd_ana_q) : '0;
  assign res_o.payload.read_binary  = s1_read_q ? BinaryW'(rd_bin_q) : '0;

endmodule

FILE: sv/pwc_skid.sv
// Output register with a skid entry so the result side never stalls the core combinationally.
module pwc_skid (
  input  logic       clk_i,
  input  logic       rst_ni,
  pwc_chan_if.sink   in_i,
  pwc_chan_if.source out_o
);
  import pwc_pkg::*;

  logic      out_valid_q;
  logic      skid_valid_q;
  out_item_t out_item_q;
  out_item_t skid_item_q;
  logic      in_acc;
  logic      out_free;

  assign in_i.ready    = !skid_valid_q;
  assign in_acc        = in_i.valid && in_i.ready;
  assign out_free      = out_o.ready || !out_valid_q;
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_item_q;

  // Advance the output register, park an item in the skid entry on a stall
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_acc;
      end
    end else if (in_acc) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_item_q <= skid_item_q;
      end else if (in_acc) begin
        out_item_q <= in_i.payload;
      end
    end else if (in_acc) begin
      skid_item_q <= in_i.payload;
    end
  end

endmodule

FILE: sv/pretrigger_waveform_capture.sv
// Each result is registered in the core's result stage and then in the skid output register.
// Throughput: one item per cycle while out_o takes results; each item makes one access
// to the single write / registered-read sample ring, and the output skid keeps input open.
// Reset (rst_ni low, asynchronous): capture stopped, counters, positions,
// latched source and pre-trigger register cleared; sample ring not cleared.
module pretrigger_waveform_capture #(
  parameter int unsigned ANALOG_CHANNELS = pwc_pkg::AnalogChannels,
  parameter int unsigned BINARY_CHANNELS = pwc_pkg::BinaryChannels
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pwc_pkg::ApbAddrW-1:0] paddr,
  input  logic [pwc_pkg::ApbDataW-1:0] pwdata,
  output logic [pwc_pkg::ApbDataW-1:0] prdata,
  output logic                         pready,
  pwc_chan_if.sink                     in_i,
  pwc_chan_if.source                   out_o
);
  import pwc_pkg::*;

  logic [PreW-1:0]    pre_periods_q;
  logic [RegIdxW-1:0] reg_idx;
  logic               cfg_wr;

  pwc_chan_if #(.item_t(out_item_t)) res_ch ();

  // Register file: one byte-wide register at index zero
  assign reg_idx = paddr[ApbAddrW-1:2];
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && (reg_idx == RegPreTriggerPeriods);
  assign prdata  = (psel && (reg_idx == RegPreTriggerPeriods)) ?
                   ApbDataW'(pre_periods_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_periods_q <= '0;
    end else if (cfg_wr) begin
      pre_periods_q <= pwdata[PreW-1:0];
    end
  end

  pwc_core #(
    .ANALOG_CHANNELS (ANALOG_CHANNELS),
    .BINARY_CHANNELS (BINARY_CHANNELS)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pre_periods_i (pre_periods_q),
    .in_i          (in_i),
    .res_o         (res_ch)
  );

  pwc_skid u_skid (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (res_ch),
    .out_o  (out_o)
  );

endmodule

FILE: test/pretrigger_waveform_capture_tb.sv
// Self-checking testbench for the pre-trigger waveform capture buffer.
module pretrigger_waveform_capture_tb;
  import pwc_pkg::*;

  // Request codes that the block must treat as no-ops
  localparam logic [ReqW-1:0] ReqUnusedFirst = 3'd5;
  localparam logic [ReqW-1:0] ReqUnusedLast  = 3'd7;

  localparam logic [ApbAddrW-1:0] PreRegAddr = ApbAddrW'(4 * RegPreTriggerPeriods);

  localparam logic [AnalogW-1:0] AnalogMask = (AnalogChannels * ChanW >= AnalogW) ?
      {AnalogW{1'b1}} : ((AnalogW'(1) << (AnalogChannels * ChanW)) - 1'b1);
  localparam logic [BinaryW-1:0] BinaryMask = (BinaryChannels >= BinaryW) ?
      {BinaryW{1'b1}} : ((BinaryW'(1) << BinaryChannels) - 1'b1);

  localparam int unsigned IdlePct      = 32;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned TailCycles   = 8;
  localparam int unsigned StallLimit   = 4000;
  localparam int unsigned RandomPhases = 3;

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  pwc_chan_if #(.item_t(in_item_t))  sample_ch ();
  pwc_chan_if #(.item_t(out_item_t)) status_ch ();

  pretrigger_waveform_capture dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (sample_ch),
    .out_o   (status_ch)
  );

  // Mirror of the capture state
  logic [AnalogW-1:0] ring_analog [CaptureDepth];
  logic [BinaryW-1:0] ring_binary [CaptureDepth];
  bit                 stored_ok   [CaptureDepth];
  bit                 stored_any;
  logic [PosW-1:0]    last_stored;
  logic [PreW-1:0]    pre_periods;
  logic [CountW-1:0]  cap_window;
  logic [PosW-1:0]    cap_newest;
  logic [CountW-1:0]  cap_count;
  logic               cap_running;
  logic               cap_triggered;
  logic [PosW-1:0]    cap_end;
  logic [SourceW-1:0] cap_source;

  out_item_t pending_status [$];

  int unsigned mismatches      = 0;
  int unsigned items_sent      = 0;
  int unsigned effective_items = 0;
  int unsigned statuses_seen   = 0;
  int unsigned captures_done   = 0;
  int unsigned settings_count  = 0;
  int unsigned setting_lo      = 255;
  int unsigned setting_hi      = 0;
  bit          tx_steady       = 1'b0;
  bit          rx_steady       = 1'b0;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Pre-trigger window length in samples for a requested number of periods
  function automatic logic [CountW-1:0] window_for(input logic [PreW-1:0] periods);
    int unsigned span;
    span = 32'(periods);
    if (span <= 1) begin
      span = DefaultPrePeriods;
    end else if (span > CapturePeriods / 2) begin
      span = CapturePeriods / 2;
    end
    span = span * SamplesPerPeriod;
    if (span > CaptureDepth) begin
      span = CaptureDepth;
    end
    return CountW'(span);
  endfunction

  function automatic void clear_capture_model();
    stored_any    = 1'b0;
    last_stored   = '0;
    pre_periods   = '0;
    cap_window    = '0;
    cap_newest    = '0;
    cap_count     = '0;
    cap_running   = 1'b0;
    cap_triggered = 1'b0;
    cap_end       = '0;
    cap_source    = '0;
    foreach (stored_ok[i]) stored_ok[i] = 1'b0;
  endfunction

  // Apply one item to the mirror and return the status it should produce
  function automatic out_item_t predict_capture(input in_item_t item);
    out_item_t       res;
    logic [PosW-1:0] slot;
    res = '0;
    case (item.req_type)
      ReqTick: begin
        if (cap_running) begin
          if (cap_count == '0 || cap_newest == PosW'(CaptureDepth - 1)) begin
            slot = '0;
          end else begin
            slot = cap_newest + 1'b1;
          end
          ring_analog[slot] = item.analog_samples & AnalogMask;
          ring_binary[slot] = item.binary_inputs & BinaryMask;
          stored_ok[slot]   = 1'b1;
          stored_any        = 1'b1;
          last_stored       = slot;
          effective_items++;
          if (!cap_triggered) begin
            // slide the pre-trigger window once it is full
            if (cap_window > cap_count) begin
              cap_count++;
            end
            cap_newest = slot;
          end else if (cap_count < CountW'(CaptureDepth)) begin
            cap_count++;
            cap_newest = slot;
          end else begin
            // sample on a full buffer closes the capture
            cap_end            = slot;
            cap_running        = 1'b0;
            cap_triggered      = 1'b0;
            cap_newest         = '0;
            cap_count          = '0;
            res.capture_done   = 1'b1;
            captures_done++;
          end
        end
      end
      ReqTrigger: begin
        if (cap_running && !cap_triggered) begin
          cap_triggered = 1'b1;
          cap_source    = item.trigger_source;
          effective_items++;
        end
      end
      ReqStart: begin
        cap_window    = window_for(pre_periods);
        cap_newest    = '0;
        cap_count     = '0;
        cap_triggered = 1'b0;
        cap_end       = '0;
        cap_source    = '0;
        cap_running   = 1'b1;
        effective_items++;
      end
      ReqStop: begin
        if (cap_running) begin
          effective_items++;
        end
        cap_running = 1'b0;
      end
      ReqRead: begin
        // read_position cannot exceed the ring, so no out-of-range case arises
        res.read_analog = ring_analog[item.read_position];
        res.read_binary = ring_binary[item.read_position];
        effective_items++;
      end
      default: ;
    endcase
    res.capture_state       = cap_running ? (cap_triggered ? CapPost : CapPre) : CapStopped;
    res.write_position      = cap_newest;
    res.stored_count        = cap_count;
    res.end_position        = cap_end;
    res.held_trigger_source = cap_source;
    return res;
  endfunction

  function automatic in_item_t make_item(input logic [ReqW-1:0] req,
                                         input logic [AnalogW-1:0] analog = '0,
                                         input logic [BinaryW-1:0] bin = '0,
                                         input logic [SourceW-1:0] src = '0,
                                         input logic [PosW-1:0] pos = '0);
    in_item_t it;
    it.req_type       = req;
    it.analog_samples = analog;
    it.binary_inputs  = bin;
    it.trigger_source = src;
    it.read_position  = pos;
    return it;
  endfunction

  function automatic in_item_t random_item(input logic [ReqW-1:0] req);
    return make_item(req, {$urandom, $urandom}, BinaryW'($urandom), SourceW'($urandom),
                     PosW'($urandom));
  endfunction

  // Only positions already written may be read back
  function automatic logic [PosW-1:0] pick_stored();
    int unsigned pos;
    pos = $urandom_range(CaptureDepth - 1);
    if (!stored_ok[pos]) begin
      pos = 32'(last_stored);
    end
    return PosW'(pos);
  endfunction

  // Send one item, idling at random first; returns at the accepting edge
  task automatic send_item(input in_item_t item);
    logic taken;
    while (!tx_steady && $urandom_range(99) < IdlePct) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    sample_ch.valid   <= 1'b1;
    sample_ch.payload <= item;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = sample_ch.ready;
      @(posedge clk_i);
    end
    pending_status.push_back(predict_capture(item));
    items_sent++;
  endtask

  // Drop valid and wait until every expected status has arrived
  task automatic drain_status(input int unsigned settle);
    sample_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_status.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  // Write the pre-trigger register, then read it back
  task automatic write_pre_periods(input logic [PreW-1:0] value);
    logic                done_flag;
    logic [ApbDataW-1:0] readback;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PreRegAddr;
    pwdata  <= ApbDataW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    done_flag = 1'b0;
    while (!done_flag) begin
      @(negedge clk_i);
      done_flag = pready;
      @(posedge clk_i);
    end
    pre_periods = value;
    settings_count++;
    if (32'(value) < setting_lo) setting_lo = 32'(value);
    if (32'(value) > setting_hi) setting_hi = 32'(value);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    done_flag = 1'b0;
    readback  = '0;
    while (!done_flag) begin
      @(negedge clk_i);
      done_flag = pready;
      readback  = prdata;
      @(posedge clk_i);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    check_field("pre_trigger_periods readback", 64'(value), 64'(readback));
  endtask

  // Mostly sample ticks, with read-backs and ignored requests mixed in
  task automatic run_samples(input int unsigned n);
    int unsigned r;
    in_item_t    it;
    repeat (n) begin
      r  = $urandom_range(99);
      it = random_item(ReqTick);
      if (r < 8 && stored_any) begin
        it.req_type      = ReqRead;
        it.read_position = pick_stored();
      end else if (r < 10) begin
        it.req_type = ReqW'($urandom_range(ReqUnusedLast, ReqUnusedFirst));
      end else if (r < 13 && cap_triggered) begin
        it.req_type = ReqTrigger;
      end
      send_item(it);
    end
  endtask

  // Requests while stopped: all ignored, no entry written yet so no reads
  task automatic test_stopped_requests();
    send_item(make_item(ReqTick, {AnalogW{1'b1}}, {BinaryW{1'b1}}, '1, '1));
    send_item(make_item(ReqTrigger, '0, '0, {SourceW{1'b1}}));
    send_item(make_item(ReqStop));
    send_item(make_item(ReqUnusedFirst, {AnalogW{1'b1}}));
    send_item(make_item(ReqUnusedFirst + 1'b1));
    send_item(make_item(ReqUnusedLast, '0, {BinaryW{1'b1}}));
  endtask

  // Short capture with extreme values, repeated trigger, stop and restart
  task automatic test_directed_capture();
    drain_status(SettleCycles);
    write_pre_periods('0);
    send_item(make_item(ReqStart));
    send_item(make_item(ReqTick, '0, '0));
    send_item(make_item(ReqTick, {AnalogW{1'b1}}, {BinaryW{1'b1}}));
    send_item(make_item(ReqTick, 64'hAAAA_5555_F00F_0FF0, 16'hA5C3));
    send_item(make_item(ReqTrigger, '0, '0, {SourceW{1'b1}}));
    send_item(make_item(ReqTrigger, '0, '0, 16'h1234));
    send_item(make_item(ReqTick, 64'h0123_4567_89AB_CDEF, 16'hFF00));
    for (int unsigned i = 0; i < 4; i++) begin
      send_item(make_item(ReqRead, '0, '0, '0, PosW'(i)));
    end
    send_item(make_item(ReqStop));
    send_item(make_item(ReqTick, {AnalogW{1'b1}}, {BinaryW{1'b1}}));
    send_item(make_item(ReqTrigger, '0, '0, 16'h00FF));
    // restart clears the counters but keeps the ring contents
    send_item(make_item(ReqStart));
    send_item(make_item(ReqRead, '0, '0, '0, PosW'(1)));
    send_item(make_item(ReqTick, 64'hFFFF_0000_FFFF_0000, 16'h0001));
    send_item(make_item(ReqRead, '0, '0, '0, '0));
    send_item(make_item(ReqStop));
  endtask

  // Trigger somewhere around the window and run until the capture closes
  task automatic capture_to_end();
    run_samples($urandom_range(cap_window + 20, cap_window / 2));
    send_item(random_item(ReqTrigger));
    run_samples($urandom_range(20));
    // hold the sender until the block has caught up
    drain_status(0);
    while (cap_running) run_samples(1);
    send_item(random_item(ReqTick));
    send_item(make_item(ReqRead, '0, '0, '0, cap_end));
  endtask

  // Fill the window, then break the capture off by a stop, at random after a trigger or restart
  task automatic capture_abort();
    run_samples(cap_window + $urandom_range(24));
    if ($urandom_range(1)) begin
      send_item(random_item(ReqTrigger));
      run_samples($urandom_range(40, 1));
    end
    if ($urandom_range(1)) begin
      send_item(random_item(ReqStart));
      run_samples($urandom_range(30, 1));
    end
    send_item(random_item(ReqStop));
    send_item(random_item(ReqTick));
    send_item(random_item(ReqTrigger));
  endtask

  // Capture sequences with random content over several register settings
  task automatic test_random_captures();
    int unsigned     phase;
    logic [PreW-1:0] setting;
    phase = 0;
    while (phase < RandomPhases) begin
      case (phase)
        0:       setting = PreW'(1);
        1:       setting = {PreW{1'b1}};
        2:       setting = PreW'($urandom_range(CapturePeriods / 2, 2));
        default: setting = PreW'($urandom_range(255));
      endcase
      drain_status(SettleCycles);
      write_pre_periods(setting);
      // one full stretch with no idling on either side
      tx_steady = (phase == 1);
      rx_steady = (phase == 1);
      send_item(random_item(ReqStart));
      if (phase % 2 == 1) begin
        capture_to_end();
      end else begin
        capture_abort();
      end
      tx_steady = 1'b0;
      rx_steady = 1'b0;
      phase++;
    end
  endtask

  // Receiver: stall at random
  initial begin
    status_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      status_ch.ready <= rx_steady || ($urandom_range(99) >= IdlePct);
    end
  end

  // Compare each accepted status item with the oldest expectation
  initial begin : status_checker
    out_item_t got;
    out_item_t want;
    forever begin
      @(negedge clk_i);
      if (status_ch.valid && status_ch.ready) begin
        got = status_ch.payload;
        if (pending_status.size() == 0) begin
          $error("status item with nothing expected: %0h", got);
          mismatches++;
        end else begin
          want = pending_status.pop_front();
          statuses_seen++;
          check_field("capture_state", 64'(want.capture_state), 64'(got.capture_state));
          check_field("write_position", 64'(want.write_position),
                      64'(got.write_position));
          check_field("stored_count", 64'(want.stored_count), 64'(got.stored_count));
          check_field("capture_done", 64'(want.capture_done), 64'(got.capture_done));
          check_field("end_position", 64'(want.end_position), 64'(got.end_position));
          check_field("held_trigger_source", 64'(want.held_trigger_source),
                      64'(got.held_trigger_source));
          check_field("read_analog", want.read_analog, got.read_analog);
          check_field("read_binary", 64'(want.read_binary), 64'(got.read_binary));
        end
      end
    end
  end

  // Abort the run if nothing moves for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(negedge clk_i);
      if ((sample_ch.valid && sample_ch.ready) || (status_ch.valid && status_ch.ready) ||
          psel) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $error("no handshake for %0d cycles", StallLimit);
    $display("end of test: mismatches");
    $finish;
  end

  // Stimulus
  initial begin
    rst_ni            = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    sample_ch.valid   = 1'b0;
    sample_ch.payload = '0;
    clear_capture_model();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_stopped_requests();
    test_directed_capture();
    test_random_captures();

    drain_status(TailCycles);
    if (pending_status.size() != 0) begin
      $error("%0d status items never arrived", pending_status.size());
      mismatches++;
    end
    $display("Run: %0d items sent (%0d took effect), %0d status items checked, %0d captures",
             items_sent, effective_items, statuses_seen, captures_done);
    $display("Pre-trigger register written %0d times, values %0d to %0d",
             settings_count, setting_lo, setting_hi);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
